FILE: src/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, codes, controller states and command/status structs.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int WIDTH  = 64;                  // working width of the datapath
    localparam int IO_W   = 64;                  // port width of operands
    localparam int DEN_W  = 63;                  // port width of the result denominator
    localparam int KIND_W = 3;
    localparam int KW     = $clog2(WIDTH);       // bit index / shift count width
    localparam int CW     = $clog2(WIDTH + 1);   // iteration counter width

    localparam logic [WIDTH-1:0] SIGN_MSK = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic [WIDTH-1:0] MAX_POS  = ~SIGN_MSK;

    typedef enum logic [KIND_W-1:0] {
        K_ADD  = 3'd0,
        K_SUB  = 3'd1,
        K_MUL  = 3'd2,
        K_DIV  = 3'd3,
        K_CMP  = 3'd4,
        K_RCP  = 3'd5,
        K_POW  = 3'd6,
        K_NORM = 3'd7
    } kind_t;

    // register file entries
    typedef enum logic [2:0] {
        R_AN = 3'd0,
        R_AD = 3'd1,
        R_BN = 3'd2,
        R_BD = 3'd3,
        R_RN = 3'd4,
        R_RD = 3'd5,
        R_T0 = 3'd6,
        R_T1 = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        OP_MOV    = 4'd0,
        OP_NEG    = 4'd1,
        OP_ADD    = 4'd2,
        OP_SET1   = 4'd3,
        OP_CMP    = 4'd4,
        OP_MUL    = 4'd5,
        OP_DIVW   = 4'd6,
        OP_DIVMAG = 4'd7,
        OP_DIVU   = 4'd8,
        OP_GCD    = 4'd9
    } op_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_RD_CHK,
        ST_RD_NEGN,
        ST_RD_NEGD,
        ST_RD_GCD,
        ST_RD_DIVN,
        ST_RD_DIVD,
        ST_CPY_N,
        ST_CPY_D,
        ST_B_DONE,
        ST_SUB_NEG,
        ST_ADD_1,
        ST_ADD_2,
        ST_ADD_3,
        ST_ADD_4,
        ST_ADD_5,
        ST_ADD_6,
        ST_ADD_7,
        ST_ADD_8,
        ST_ADD_9,
        ST_MUL_1,
        ST_MUL_2,
        ST_DV_1,
        ST_DV_2,
        ST_DV_3,
        ST_CMP_1,
        ST_CMP_2,
        ST_CMP_3,
        ST_RCP_1,
        ST_RCP_2,
        ST_PW_INIT_N,
        ST_PW_INIT_D,
        ST_PW_SQ_N,
        ST_PW_SQ_D,
        ST_PW_BIT,
        ST_PW_M_N,
        ST_PW_M_D,
        ST_PW_NEXT,
        ST_PW_SIGN,
        ST_PW_RC_1,
        ST_PW_RC_2,
        ST_PW_RC_3,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic           go;
        op_t            op;
        reg_idx_t       dst;
        reg_idx_t       src1;
        reg_idx_t       src2;
        logic [KW-1:0]  bit_idx;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic s1_zero;
        logic s1_neg;
        logic exp_bit;
    } sts_t;

    typedef struct packed {
        logic [WIDTH-1:0] a_num;
        logic [WIDTH-1:0] a_den;
        logic [WIDTH-1:0] b_num;
        logic [WIDTH-1:0] b_den;
    } ld_t;

endpackage
`default_nettype wire

FILE: src/rau_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
interface rau_req_if import rau_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [IO_W-1:0]   a_num;
    logic signed [IO_W-1:0]   a_den;
    logic signed [IO_W-1:0]   b_num;
    logic signed [IO_W-1:0]   b_den;

    modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if import rau_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [IO_W-1:0]   res_num;
    logic [DEN_W-1:0]         res_den;
    logic                     is_less;
    logic                     is_equal;
    logic                     status;
    logic                     overflow;

    modport source (output valid, res_num, res_den, is_less, is_equal, status, overflow,
                    input ready);
    modport sink   (input valid, res_num, res_den, is_less, is_equal, status, overflow,
                    output ready);
endinterface
`default_nettype wire

FILE: src/rau_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit datapath
// Register file, combinational ALU, shift-add multiplier, restoring divider
// and binary gcd sharing one set of iteration registers.
// ----------------------------------------------------------------------------
module rau_datapath import rau_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire ld_t               ld,
    input  wire cmd_t              cmd,
    output sts_t                   sts,
    output logic [WIDTH-1:0]       rn,
    output logic [WIDTH-1:0]       rd,
    output logic                   less,
    output logic                   equal,
    output logic                   ovf
);

    logic [WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg, rn_reg, rd_reg, t0_reg, t1_reg;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] aux_reg, aux_next;
    logic [WIDTH-1:0] opd_reg;
    logic [KW-1:0]    k_reg, k_next;
    logic [CW-1:0]    cnt_reg;
    logic             sign_reg;
    logic             busy_reg;
    logic             ovf_reg;
    logic             less_reg;
    logic             equal_reg;

    logic [WIDTH-1:0] s1, s2, mag1, mag2, bn_mag;
    logic             neg1, neg2;
    logic             single;
    logic [WIDTH-1:0] sres, mres, wdata;
    logic             sovf, movf, mfin;
    logic             done, wr_en, start;

    // operand select
    always_comb
    begin
        case (cmd.src1)
            R_AN:    s1 = an_reg;
            R_AD:    s1 = ad_reg;
            R_BN:    s1 = bn_reg;
            R_BD:    s1 = bd_reg;
            R_RN:    s1 = rn_reg;
            R_RD:    s1 = rd_reg;
            R_T0:    s1 = t0_reg;
            R_T1:    s1 = t1_reg;
            default: s1 = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.src2)
            R_AN:    s2 = an_reg;
            R_AD:    s2 = ad_reg;
            R_BN:    s2 = bn_reg;
            R_BD:    s2 = bd_reg;
            R_RN:    s2 = rn_reg;
            R_RD:    s2 = rd_reg;
            R_T0:    s2 = t0_reg;
            R_T1:    s2 = t1_reg;
            default: s2 = '0;
        endcase
    end

    assign neg1   = s1[WIDTH-1];
    assign neg2   = s2[WIDTH-1];
    assign mag1   = neg1 ? ('0 - s1) : s1;
    assign mag2   = neg2 ? ('0 - s2) : s2;
    assign bn_mag = bn_reg[WIDTH-1] ? ('0 - bn_reg) : bn_reg;

    always_comb
    begin
        case (cmd.op)
            OP_MOV, OP_NEG, OP_ADD, OP_SET1, OP_CMP: single = 1'b1;
            default:                                 single = 1'b0;
        endcase
    end

    // combinational ops
    always_comb
    begin
        sres = '0;
        sovf = 1'b0;
        case (cmd.op)
            OP_MOV:  sres = s1;
            OP_NEG:
            begin
                sres = '0 - s1;
                sovf = (s1 == SIGN_MSK);
            end
            OP_ADD:
            begin
                sres = s1 + s2;
                sovf = (neg1 == neg2) && (sres[WIDTH-1] != neg1);
            end
            OP_SET1: sres = WIDTH'(1);
            default: sres = '0;
        endcase
    end

    // iterative ops: result once finished
    always_comb
    begin
        mres = sign_reg ? ('0 - aux_reg) : aux_reg;
        movf = 1'b0;
        mfin = (cnt_reg == CW'(WIDTH));
        case (cmd.op)
            OP_MUL:
                movf = (acc_reg != '0) || (aux_reg > (sign_reg ? SIGN_MSK : MAX_POS));
            OP_DIVW:
                movf = !sign_reg && aux_reg[WIDTH-1];
            OP_GCD:
            begin
                mres = (acc_reg | aux_reg) << k_reg;
                mfin = (acc_reg == '0) || (aux_reg == '0);
            end
            default: movf = 1'b0;
        endcase
    end

    // one step of the shared iteration
    always_comb
    begin
        logic [WIDTH:0]   sum;
        logic [WIDTH:0]   rem_sh;
        logic             ge;
        logic [WIDTH-1:0] d_uv, d_vu;
        sum      = '0;
        rem_sh   = '0;
        ge       = 1'b0;
        d_uv     = acc_reg - aux_reg;
        d_vu     = aux_reg - acc_reg;
        acc_next = acc_reg;
        aux_next = aux_reg;
        k_next   = k_reg;
        case (cmd.op)
            OP_MUL:
            begin
                sum      = {1'b0, acc_reg} + (aux_reg[0] ? {1'b0, opd_reg} : '0);
                acc_next = sum[WIDTH:1];
                aux_next = {sum[0], aux_reg[WIDTH-1:1]};
            end
            OP_DIVW, OP_DIVMAG, OP_DIVU:
            begin
                rem_sh   = {acc_reg, aux_reg[WIDTH-1]};
                ge       = rem_sh >= {1'b0, opd_reg};
                acc_next = ge ? WIDTH'(rem_sh - {1'b0, opd_reg}) : rem_sh[WIDTH-1:0];
                aux_next = {aux_reg[WIDTH-2:0], ge};
            end
            OP_GCD:
            begin
                if (!acc_reg[0] && !aux_reg[0])
                begin
                    acc_next = acc_reg >> 1;
                    aux_next = aux_reg >> 1;
                    k_next   = KW'(k_reg + 1'b1);
                end
                else if (!acc_reg[0])
                    acc_next = acc_reg >> 1;
                else if (!aux_reg[0])
                    aux_next = aux_reg >> 1;
                else if (acc_reg >= aux_reg)
                    acc_next = d_uv >> 1;
                else
                    aux_next = d_vu >> 1;
            end
            default: acc_next = acc_reg;
        endcase
    end

    assign start = !busy_reg && cmd.go && !single;
    assign done  = (!busy_reg && cmd.go && single) || (busy_reg && mfin);
    assign wr_en = done && (cmd.op != OP_CMP);
    assign wdata = busy_reg ? mres : sres;

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            less_reg  <= 1'b0;
            equal_reg <= 1'b0;
        end
        else if (load)
        begin
            busy_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            less_reg  <= 1'b0;
            equal_reg <= 1'b0;
        end
        else
        begin
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && mfin)
                busy_reg <= 1'b0;
            if (done && (busy_reg ? movf : sovf))
                ovf_reg <= 1'b1;
            if (done && cmd.op == OP_CMP)
            begin
                less_reg  <= $signed(s1) < $signed(s2);
                equal_reg <= (an_reg == bn_reg) && (ad_reg == bd_reg);
            end
        end
    end

    // register file and iteration registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            an_reg <= ld.a_num;
            ad_reg <= ld.a_den;
            bn_reg <= ld.b_num;
            bd_reg <= ld.b_den;
        end
        else if (wr_en)
        begin
            case (cmd.dst)
                R_AN:    an_reg <= wdata;
                R_AD:    ad_reg <= wdata;
                R_BN:    bn_reg <= wdata;
                R_BD:    bd_reg <= wdata;
                R_RN:    rn_reg <= wdata;
                R_RD:    rd_reg <= wdata;
                R_T0:    t0_reg <= wdata;
                R_T1:    t1_reg <= wdata;
                default: t1_reg <= wdata;
            endcase
        end

        if (start)
        begin
            cnt_reg <= '0;
            k_reg   <= '0;
            case (cmd.op)
                OP_MUL:
                begin
                    acc_reg  <= '0;
                    aux_reg  <= mag2;
                    opd_reg  <= mag1;
                    sign_reg <= neg1 ^ neg2;
                end
                OP_DIVW:
                begin
                    acc_reg  <= '0;
                    aux_reg  <= mag1;
                    opd_reg  <= mag2;
                    sign_reg <= neg1 ^ neg2;
                end
                OP_DIVMAG:
                begin
                    acc_reg  <= '0;
                    aux_reg  <= mag1;
                    opd_reg  <= s2;
                    sign_reg <= neg1;
                end
                OP_DIVU:
                begin
                    acc_reg  <= '0;
                    aux_reg  <= mag1;
                    opd_reg  <= s2;
                    sign_reg <= 1'b0;
                end
                default:
                begin
                    acc_reg  <= mag1;
                    aux_reg  <= mag2;
                    opd_reg  <= '0;
                    sign_reg <= 1'b0;
                end
            endcase
        end
        else if (busy_reg && !mfin)
        begin
            acc_reg <= acc_next;
            aux_reg <= aux_next;
            k_reg   <= k_next;
            cnt_reg <= CW'(cnt_reg + 1'b1);
        end
    end

    assign sts.done    = done;
    assign sts.s1_zero = (s1 == '0);
    assign sts.s1_neg  = neg1;
    assign sts.exp_bit = bn_mag[cmd.bit_idx];

    assign rn    = rn_reg;
    assign rd    = rd_reg;
    assign less  = less_reg;
    assign equal = equal_reg;
    assign ovf   = ovf_reg;

endmodule
`default_nettype wire

FILE: src/rau_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit controller
// Sequences datapath ops per kind; reduce is a shared sub-sequence with a
// return state and a selectable register pair.
// ----------------------------------------------------------------------------
module rau_ctrl import rau_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   req_valid,
    output logic        req_ready,
    input  wire kind_t  kind,
    output logic        load,
    output cmd_t        cmd,
    input  wire sts_t   sts,
    input  wire logic   out_free,
    output logic        fin,
    output logic        err
);

    state_t        state_reg, state_next;
    state_t        ret_reg, ret_next;
    reg_idx_t      nsel_reg, nsel_next;
    reg_idx_t      dsel_reg, dsel_next;
    kind_t         kind_reg, kind_next;
    logic [KW-1:0] idx_reg, idx_next;
    logic          err_reg, err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            nsel_reg  <= R_AN;
            dsel_reg  <= R_AD;
            kind_reg  <= K_ADD;
            idx_reg   <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            nsel_reg  <= nsel_next;
            dsel_reg  <= dsel_next;
            kind_reg  <= kind_next;
            idx_reg   <= idx_next;
            err_reg   <= err_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        nsel_next   = nsel_reg;
        dsel_next   = dsel_reg;
        kind_next   = kind_reg;
        idx_next    = idx_reg;
        err_next    = err_reg;
        req_ready   = 1'b0;
        load        = 1'b0;
        fin         = 1'b0;
        cmd.go      = 1'b0;
        cmd.op      = OP_MOV;
        cmd.dst     = R_T0;
        cmd.src1    = R_T0;
        cmd.src2    = R_T0;
        cmd.bit_idx = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    load       = 1'b1;
                    kind_next  = kind;
                    err_next   = 1'b0;
                    nsel_next  = R_AN;
                    dsel_next  = R_AD;
                    ret_next   = ST_CPY_N;
                    state_next = ST_RD_CHK;
                end
            end

            // reduce(nsel/dsel)
            ST_RD_CHK:
            begin
                cmd.src1 = dsel_reg;
                if (sts.s1_zero)
                begin
                    err_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else if (sts.s1_neg)
                    state_next = ST_RD_NEGN;
                else
                    state_next = ST_RD_GCD;
            end
            ST_RD_NEGN:
            begin
                cmd.go = 1'b1; cmd.op = OP_NEG; cmd.dst = nsel_reg; cmd.src1 = nsel_reg;
                if (sts.done) state_next = ST_RD_NEGD;
            end
            ST_RD_NEGD:
            begin
                cmd.go = 1'b1; cmd.op = OP_NEG; cmd.dst = dsel_reg; cmd.src1 = dsel_reg;
                if (sts.done) state_next = ST_RD_GCD;
            end
            ST_RD_GCD:
            begin
                cmd.go = 1'b1; cmd.op = OP_GCD; cmd.dst = R_T0;
                cmd.src1 = nsel_reg; cmd.src2 = dsel_reg;
                if (sts.done) state_next = ST_RD_DIVN;
            end
            ST_RD_DIVN:
            begin
                cmd.go = 1'b1; cmd.op = OP_DIVMAG; cmd.dst = nsel_reg;
                cmd.src1 = nsel_reg; cmd.src2 = R_T0;
                if (sts.done) state_next = ST_RD_DIVD;
            end
            ST_RD_DIVD:
            begin
                cmd.go = 1'b1; cmd.op = OP_DIVU; cmd.dst = dsel_reg;
                cmd.src1 = dsel_reg; cmd.src2 = R_T0;
                if (sts.done) state_next = ret_reg;
            end

            // result starts as the reduced first operand
            ST_CPY_N:
            begin
                cmd.go = 1'b1; cmd.dst = R_RN; cmd.src1 = R_AN;
                if (sts.done) state_next = ST_CPY_D;
            end
            ST_CPY_D:
            begin
                cmd.go = 1'b1; cmd.dst = R_RD; cmd.src1 = R_AD;
                if (sts.done)
                begin
                    if (kind_reg <= K_CMP)
                    begin
                        nsel_next  = R_BN;
                        dsel_next  = R_BD;
                        ret_next   = ST_B_DONE;
                        state_next = ST_RD_CHK;
                    end
                    else if (kind_reg == K_RCP)
                        state_next = ST_RCP_1;
                    else if (kind_reg == K_POW)
                        state_next = ST_PW_INIT_N;
                    else
                        state_next = ST_FIN;
                end
            end
            ST_B_DONE:
            begin
                case (kind_reg)
                    K_ADD:   state_next = ST_ADD_1;
                    K_SUB:   state_next = ST_SUB_NEG;
                    K_MUL:   state_next = ST_MUL_1;
                    K_DIV:   state_next = ST_DV_1;
                    default: state_next = ST_CMP_1;
                endcase
            end

            // add over the lcm of the denominators; subtract first negates the second numerator
            ST_SUB_NEG:
            begin
                cmd.go = 1'b1; cmd.op = OP_NEG; cmd.dst = R_BN; cmd.src1 = R_BN;
                if (sts.done) state_next = ST_ADD_1;
            end
            ST_ADD_1:
            begin
                cmd.go = 1'b1; cmd.op = OP_GCD; cmd.dst = R_T0;
                cmd.src1 = R_AD; cmd.src2 = R_BD;
                if (sts.done) state_next = ST_ADD_2;
            end
            ST_ADD_2:
            begin
                cmd.go = 1'b1; cmd.op = OP_DIVMAG; cmd.dst = R_T0;
                cmd.src1 = R_AD; cmd.src2 = R_T0;
                if (sts.done) state_next = ST_ADD_3;
            end
            ST_ADD_3:
            begin
                cmd.go = 1'b1; cmd.op = OP_MUL; cmd.dst = R_T0;
                cmd.src1 = R_T0; cmd.src2 = R_BD;
                if (sts.done) state_next = ST_ADD_4;
            end
            ST_ADD_4:
            begin
                cmd.go = 1'b1; cmd.op = OP_DIVW; cmd.dst = R_T1;
                cmd.src1 = R_T0; cmd.src2 = R_AD;
                if (sts.done) state_next = ST_ADD_5;
            end
            ST_ADD_5:
            begin
                cmd.go = 1'b1; cmd.op = OP_MUL; cmd.dst = R_RN;
                cmd.src1 = R_AN; cmd.src2 = R_T1;
                if (sts.done) state_next = ST_ADD_6;
            end
            ST_ADD_6:
            begin
                cmd.go = 1'b1; cmd.dst = R_RD; cmd.src1 = R_T0;
                if (sts.done) state_next = ST_ADD_7;
            end
            ST_ADD_7:
            begin
                cmd.go = 1'b1; cmd.op = OP_DIVW; cmd.dst = R_T1;
                cmd.src1 = R_RD; cmd.src2 = R_BD;
                if (sts.done) state_next = ST_ADD_8;
            end
            ST_ADD_8:
            begin
                cmd.go = 1'b1; cmd.op = OP_MUL; cmd.dst = R_T1;
                cmd.src1 = R_BN; cmd.src2 = R_T1;
                if (sts.done) state_next = ST_ADD_9;
            end
            ST_ADD_9:
            begin
                cmd.go = 1'b1; cmd.op = OP_ADD; cmd.dst = R_RN;
                cmd.src1 = R_RN; cmd.src2 = R_T1;
                if (sts.done)
                begin
                    nsel_next  = R_RN;
                    dsel_next  = R_RD;
                    ret_next   = ST_FIN;
                    state_next = ST_RD_CHK;
                end
            end

            // product of first and second operand
            ST_MUL_1:
            begin
                cmd.go = 1'b1; cmd.op = OP_MUL; cmd.dst = R_RN;
                cmd.src1 = R_AN; cmd.src2 = R_BN;
                if (sts.done) state_next = ST_MUL_2;
            end
            ST_MUL_2:
            begin
                cmd.go = 1'b1; cmd.op = OP_MUL; cmd.dst = R_RD;
                cmd.src1 = R_AD; cmd.src2 = R_BD;
                if (sts.done)
                begin
                    nsel_next  = R_RN;
                    dsel_next  = R_RD;
                    ret_next   = ST_FIN;
                    state_next = ST_RD_CHK;
                end
            end

            // divide: flip the second operand, reduce it, then multiply
            ST_DV_1:
            begin
                cmd.go = 1'b1; cmd.dst = R_T0; cmd.src1 = R_BN;
                if (sts.done) state_next = ST_DV_2;
            end
            ST_DV_2:
            begin
                cmd.go = 1'b1; cmd.dst = R_BN; cmd.src1 = R_BD;
                if (sts.done) state_next = ST_DV_3;
            end
            ST_DV_3:
            begin
                cmd.go = 1'b1; cmd.dst = R_BD; cmd.src1 = R_T0;
                if (sts.done)
                begin
                    nsel_next  = R_BN;
                    dsel_next  = R_BD;
                    ret_next   = ST_MUL_1;
                    state_next = ST_RD_CHK;
                end
            end

            // compare by cross products
            ST_CMP_1:
            begin
                cmd.go = 1'b1; cmd.op = OP_MUL; cmd.dst = R_T0;
                cmd.src1 = R_AN; cmd.src2 = R_BD;
                if (sts.done) state_next = ST_CMP_2;
            end
            ST_CMP_2:
            begin
                cmd.go = 1'b1; cmd.op = OP_MUL; cmd.dst = R_T1;
                cmd.src1 = R_BN; cmd.src2 = R_AD;
                if (sts.done) state_next = ST_CMP_3;
            end
            ST_CMP_3:
            begin
                cmd.go = 1'b1; cmd.op = OP_CMP; cmd.src1 = R_T0; cmd.src2 = R_T1;
                if (sts.done) state_next = ST_FIN;
            end

            // reciprocal of first operand
            ST_RCP_1:
            begin
                cmd.go = 1'b1; cmd.dst = R_RN; cmd.src1 = R_AD;
                if (sts.done) state_next = ST_RCP_2;
            end
            ST_RCP_2:
            begin
                cmd.go = 1'b1; cmd.dst = R_RD; cmd.src1 = R_AN;
                if (sts.done)
                begin
                    nsel_next  = R_RN;
                    dsel_next  = R_RD;
                    ret_next   = ST_FIN;
                    state_next = ST_RD_CHK;
                end
            end

            // square-and-multiply, MSB first over all exponent bits
            ST_PW_INIT_N:
            begin
                cmd.go = 1'b1; cmd.op = OP_SET1; cmd.dst = R_RN;
                if (sts.done) state_next = ST_PW_INIT_D;
            end
            ST_PW_INIT_D:
            begin
                cmd.go = 1'b1; cmd.op = OP_SET1; cmd.dst = R_RD;
                if (sts.done)
                begin
                    idx_next   = KW'(WIDTH - 1);
                    state_next = ST_PW_SQ_N;
                end
            end
            ST_PW_SQ_N:
            begin
                cmd.go = 1'b1; cmd.op = OP_MUL; cmd.dst = R_RN;
                cmd.src1 = R_RN; cmd.src2 = R_RN;
                if (sts.done) state_next = ST_PW_SQ_D;
            end
            ST_PW_SQ_D:
            begin
                cmd.go = 1'b1; cmd.op = OP_MUL; cmd.dst = R_RD;
                cmd.src1 = R_RD; cmd.src2 = R_RD;
                if (sts.done)
                begin
                    nsel_next  = R_RN;
                    dsel_next  = R_RD;
                    ret_next   = ST_PW_BIT;
                    state_next = ST_RD_CHK;
                end
            end
            ST_PW_BIT:
            begin
                if (sts.exp_bit)
                    state_next = ST_PW_M_N;
                else
                    state_next = ST_PW_NEXT;
            end
            ST_PW_M_N:
            begin
                cmd.go = 1'b1; cmd.op = OP_MUL; cmd.dst = R_RN;
                cmd.src1 = R_RN; cmd.src2 = R_AN;
                if (sts.done) state_next = ST_PW_M_D;
            end
            ST_PW_M_D:
            begin
                cmd.go = 1'b1; cmd.op = OP_MUL; cmd.dst = R_RD;
                cmd.src1 = R_RD; cmd.src2 = R_AD;
                if (sts.done)
                begin
                    nsel_next  = R_RN;
                    dsel_next  = R_RD;
                    ret_next   = ST_PW_NEXT;
                    state_next = ST_RD_CHK;
                end
            end
            ST_PW_NEXT:
            begin
                if (idx_reg == '0)
                    state_next = ST_PW_SIGN;
                else
                begin
                    idx_next   = KW'(idx_reg - 1'b1);
                    state_next = ST_PW_SQ_N;
                end
            end
            ST_PW_SIGN:
            begin
                cmd.src1 = R_BN;
                if (sts.s1_neg)
                    state_next = ST_PW_RC_1;
                else
                    state_next = ST_FIN;
            end
            ST_PW_RC_1:
            begin
                cmd.go = 1'b1; cmd.dst = R_T0; cmd.src1 = R_RN;
                if (sts.done) state_next = ST_PW_RC_2;
            end
            ST_PW_RC_2:
            begin
                cmd.go = 1'b1; cmd.dst = R_RN; cmd.src1 = R_RD;
                if (sts.done) state_next = ST_PW_RC_3;
            end
            ST_PW_RC_3:
            begin
                cmd.go = 1'b1; cmd.dst = R_RD; cmd.src1 = R_T0;
                if (sts.done)
                begin
                    nsel_next  = R_RN;
                    dsel_next  = R_RD;
                    ret_next   = ST_FIN;
                    state_next = ST_RD_CHK;
                end
            end

            ST_FIN:
            begin
                if (out_free)
                begin
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    assign err = err_reg;

endmodule
`default_nettype wire

FILE: src/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Normalizes two fractions and adds, subtracts, multiplies, divides,
// compares, inverts or raises to an integer power; result is reduced.
// ----------------------------------------------------------------------------
// Power runs up to 2*WIDTH multiply+reduce rounds.
// Throughput: one transaction at a time; the iterative units are the limit.
//   The next request is taken as soon as the result sits in the output register.
// Reset: rst_n async low, clears controller, flags and output valid.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rau_req_if.sink    req,
    rau_rsp_if.source  rsp
);

    cmd_t              cmd;
    sts_t              sts;
    ld_t               ld;
    logic              load;
    logic              fin;
    logic              err;
    logic              out_free;
    logic [WIDTH-1:0]  rn, rd;
    logic [IO_W-1:0]   rd_ext;
    logic              less, equal, ovf;

    logic                    out_valid_reg;
    logic signed [IO_W-1:0]  num_reg;
    logic [DEN_W-1:0]        den_reg;
    logic                    less_reg, equal_reg, status_reg, ovf_reg;

    // only the low WIDTH bits of each operand matter
    assign ld.a_num = req.a_num[WIDTH-1:0];
    assign ld.a_den = req.a_den[WIDTH-1:0];
    assign ld.b_num = req.b_num[WIDTH-1:0];
    assign ld.b_den = req.b_den[WIDTH-1:0];

    // output slot frees up when the waiting transaction is taken
    assign out_free = !out_valid_reg || rsp.ready;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .kind      (kind_t'(req.kind)),
        .load      (load),
        .cmd       (cmd),
        .sts       (sts),
        .out_free  (out_free),
        .fin       (fin),
        .err       (err)
    );

    rau_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load),
        .ld    (ld),
        .cmd   (cmd),
        .sts   (sts),
        .rn    (rn),
        .rd    (rd),
        .less  (less),
        .equal (equal),
        .ovf   (ovf)
    );

    assign rd_ext = IO_W'(rd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fin)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    // result payload; zero-denominator error forces 0/1
    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            ovf_reg    <= ovf;
            status_reg <= err;
            if (err)
            begin
                num_reg   <= '0;
                den_reg   <= DEN_W'(1);
                less_reg  <= 1'b0;
                equal_reg <= 1'b0;
            end
            else
            begin
                num_reg   <= IO_W'($signed(rn));
                den_reg   <= rd_ext[DEN_W-1:0];
                less_reg  <= less;
                equal_reg <= equal;
            end
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.res_num  = num_reg;
    assign rsp.res_den  = den_reg;
    assign rsp.is_less  = less_reg;
    assign rsp.is_equal = equal_reg;
    assign rsp.status   = status_reg;
    assign rsp.overflow = ovf_reg;

endmodule
`default_nettype wire
